FILE: hdl/ssp_pkg.sv
package ssp_pkg;

    // Fixed field widths
    localparam int VTX_W    = 5;
    localparam int VC_W     = 6;
    localparam int DIST_W   = 24;

    // Default sizing
    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int DEF_WEIGHT_BITS  = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd1;

    // Result packing: vertex_index, distance, parent, reachable, negative_cycle
    localparam int OUT_BITS = 2 * VTX_W + DIST_W + 2;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

    typedef struct packed {
        logic                     improve;
        logic signed [DIST_W-1:0] cand;
    } t_relax;

endpackage

FILE: hdl/single_source_shortest_paths.sv
// Bellman-Ford shortest paths from a configured source. Edges arrive one per
// transaction and are written to the edge memory at one per cycle while
// tready is high (edges beyond the memory depth are not stored); the edge with
// tlast set starts the solve, and input stays stalled until the last result
// has been loaded into the output register. Solving takes a setup state,
// then sweeps the stored edges in arrival order for up to vertex_count-1
// passes (fewer once a pass changes nothing) plus one checking pass, which
// stops at the first improvement it finds. A skipped edge passes S_FETCH and
// S_EREAD, a relaxed one (both ends below the vertex count and its start
// vertex reached) also S_RELAX, as the registered edge memory read is followed
// by the registered distance memory read. Results follow in ascending order,
// each through S_ORD and S_OSEND (held while the output is stalled), with tlast
// on vertex vertex_count-1. No clearing pass is needed after reset.
module single_source_shortest_paths #(
    parameter int MAX_VERTICES = ssp_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = ssp_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = ssp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tdata: edge_from, edge_to, edge_weight; tlast: last_edge
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [((2*ssp_pkg::VTX_W+WEIGHT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    // tdata: vertex_index, distance, parent, reachable, negative_cycle; tlast: last_vertex
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [ssp_pkg::OUT_DW-1:0]             o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ssp_pkg::VC_W-1:0]               i_cfg_data
);

    localparam int VTX_W  = ssp_pkg::VTX_W;
    localparam int DIST_W = ssp_pkg::DIST_W;
    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int VCW    = $clog2(MAX_VERTICES + 1);
    localparam int NW     = (VCW > ssp_pkg::VC_W) ? VCW : ssp_pkg::VC_W;
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int EW     = 2 * VTX_W + WEIGHT_BITS;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EREAD = 3'd3;
    localparam logic [2:0] S_RELAX = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OSEND = 3'd6;

    // Configuration
    logic [ssp_pkg::VC_W-1:0] r_vc;
    logic [VTX_W-1:0]         r_src;

    // Control state
    logic [2:0]              r_state, n_state;
    logic [ECW-1:0]          r_total, n_total;
    logic [ECW-1:0]          r_eidx, n_eidx;
    logic [NW-1:0]           r_pass, n_pass;
    logic [NW-1:0]           r_k, n_k;
    logic [NW-1:0]           r_nv, n_nv;
    logic                    r_check, n_check;
    logic                    r_changed, n_changed;
    logic                    r_cycle, n_cycle;
    logic [MAX_VERTICES-1:0] r_reached, n_reached;
    logic                    r_out_valid, n_out_valid;

    // Memories and their read registers
    logic [EW-1:0]            r_edge_mem [MAX_EDGES];
    logic [EW-1:0]            r_edge_rd;
    logic [DIST_W-1:0]        r_dist_mem [MAX_VERTICES];
    logic [VTX_W-1:0]         r_par_mem  [MAX_VERTICES];
    logic signed [DIST_W-1:0] r_rd_a_dist;
    logic [VTX_W-1:0]         r_rd_a_par;
    logic signed [DIST_W-1:0] r_rd_b_dist;

    logic [ssp_pkg::OUT_DW-1:0] r_out_data;
    logic                       r_out_last;

    logic                       s_fire;
    logic                       edge_we;
    logic [NW-1:0]              eff_nv;
    logic [VTX_W-1:0]           e_from;
    logic [VTX_W-1:0]           e_to;
    logic signed [WEIGHT_BITS-1:0] e_weight;
    logic                       edge_ok;
    logic [AW-1:0]              rd_a_addr;
    logic                       dist_we;
    logic [AW-1:0]              dist_wa;
    logic [DIST_W-1:0]          dist_wd;
    logic [VTX_W-1:0]           par_wd;
    logic                       load_out;
    logic                       reached_k;
    ssp_pkg::t_relax            relax;

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_cfg_ready     = 1'b1;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign edge_we         = s_fire && (r_total < ECW'(MAX_EDGES));

    always_comb begin
        if (r_vc == '0) begin
            eff_nv = NW'(1);
        end else if (NW'(r_vc) > NW'(MAX_VERTICES)) begin
            eff_nv = NW'(MAX_VERTICES);
        end else begin
            eff_nv = NW'(r_vc);
        end
    end

    assign e_from   = r_edge_rd[VTX_W-1:0];
    assign e_to     = r_edge_rd[2*VTX_W-1:VTX_W];
    assign e_weight = signed'(r_edge_rd[EW-1:2*VTX_W]);
    assign edge_ok  = (NW'(e_from) < r_nv) && (NW'(e_to) < r_nv) && r_reached[AW'(e_from)];
    assign rd_a_addr = ((r_state == S_ORD) || (r_state == S_OSEND)) ? AW'(r_k) : AW'(e_from);
    assign reached_k = r_reached[AW'(r_k)];

    ssp_relax #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .i_dist_from  (r_rd_a_dist),
        .i_dist_to    (r_rd_b_dist),
        .i_to_reached (r_reached[AW'(e_to)]),
        .i_weight     (e_weight),
        .o_relax      (relax)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc  <= ssp_pkg::VC_W'(1);
            r_src <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssp_pkg::REG_VERTEX_COUNT:  r_vc  <= i_cfg_data;
                ssp_pkg::REG_SOURCE_VERTEX: r_src <= i_cfg_data[VTX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_eidx      = r_eidx;
        n_pass      = r_pass;
        n_k         = r_k;
        n_nv        = r_nv;
        n_check     = r_check;
        n_changed   = r_changed;
        n_cycle     = r_cycle;
        n_reached   = r_reached;
        n_out_valid = r_out_valid;
        load_out    = 1'b0;
        dist_we     = 1'b0;
        dist_wa     = '0;
        dist_wd     = '0;
        par_wd      = '0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (s_fire) begin
                    if (edge_we) begin
                        n_total = r_total + ECW'(1);
                    end
                    if (i_s_axis_tlast) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_nv      = eff_nv;
                n_reached = '0;
                n_pass    = '0;
                n_changed = 1'b0;
                n_cycle   = 1'b0;
                n_eidx    = '0;
                n_k       = '0;
                if (NW'(r_src) < eff_nv) begin
                    n_reached[AW'(r_src)] = 1'b1;
                    dist_we = 1'b1;
                    dist_wa = AW'(r_src);
                    par_wd  = r_src;
                    // A single vertex gets no relaxation pass
                    n_check = (eff_nv == NW'(1));
                    n_state = S_FETCH;
                end else begin
                    n_check = 1'b1;
                    n_state = S_ORD;
                end
            end
            S_FETCH: begin
                if (r_eidx == r_total) begin
                    n_eidx    = '0;
                    n_changed = 1'b0;
                    if (r_check) begin
                        n_state = S_ORD;
                    end else if (!r_changed || (r_pass + NW'(2) == r_nv)) begin
                        n_check = 1'b1;
                    end else begin
                        n_pass = r_pass + NW'(1);
                    end
                end else begin
                    n_state = S_EREAD;
                end
            end
            S_EREAD: begin
                if (edge_ok) begin
                    n_state = S_RELAX;
                end else begin
                    n_eidx  = r_eidx + ECW'(1);
                    n_state = S_FETCH;
                end
            end
            S_RELAX: begin
                n_eidx  = r_eidx + ECW'(1);
                n_state = S_FETCH;
                if (relax.improve) begin
                    n_changed = 1'b1;
                    if (r_check) begin
                        // Any improvement in the checking pass means a negative cycle
                        n_cycle = 1'b1;
                        n_state = S_ORD;
                    end else begin
                        dist_we = 1'b1;
                        dist_wa = AW'(e_to);
                        dist_wd = relax.cand;
                        par_wd  = e_from;
                        n_reached[AW'(e_to)] = 1'b1;
                    end
                end
            end
            S_ORD: begin
                n_state = S_OSEND;
            end
            S_OSEND: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_k == r_nv - NW'(1)) begin
                        n_total = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + NW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_total     <= '0;
            r_eidx      <= '0;
            r_pass      <= '0;
            r_k         <= '0;
            r_nv        <= NW'(1);
            r_check     <= 1'b0;
            r_changed   <= 1'b0;
            r_cycle     <= 1'b0;
            r_reached   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_eidx      <= n_eidx;
            r_pass      <= n_pass;
            r_k         <= n_k;
            r_nv        <= n_nv;
            r_check     <= n_check;
            r_changed   <= n_changed;
            r_cycle     <= n_cycle;
            r_reached   <= n_reached;
            r_out_valid <= n_out_valid;
        end
    end

    // Edge memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[r_total[EAW-1:0]] <= i_s_axis_tdata[EW-1:0];
        end
        r_edge_rd <= r_edge_mem[r_eidx[EAW-1:0]];
    end

    // Distance and parent memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_wa] <= dist_wd;
            r_par_mem[dist_wa]  <= par_wd;
        end
        r_rd_a_dist <= signed'(r_dist_mem[rd_a_addr]);
        r_rd_a_par  <= r_par_mem[rd_a_addr];
        r_rd_b_dist <= signed'(r_dist_mem[AW'(e_to)]);
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {{(ssp_pkg::OUT_DW - ssp_pkg::OUT_BITS){1'b0}},
                           r_cycle,
                           reached_k,
                           reached_k ? r_rd_a_par : VTX_W'(0),
                           reached_k ? r_rd_a_dist : DIST_W'(0),
                           VTX_W'(r_k)};
            r_out_last <= (r_k == r_nv - NW'(1));
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= ECW'(MAX_EDGES))
        else $error("edge count beyond memory depth");

    a_relax_start_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX) |-> (r_reached[AW'(e_from)] && (NW'(e_to) < r_nv)))
        else $error("relaxing an edge whose start is not reached");

    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FETCH || r_state == S_EREAD || r_state == S_RELAX) && !r_check)
        |-> (r_pass + NW'(2) <= r_nv))
        else $error("relaxation pass count overrun");

    a_out_from_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_OSEND))
        else $error("result loaded outside the output state");

endmodule

FILE: hdl/ssp_relax.sv
module ssp_relax #(
    parameter int WEIGHT_BITS = ssp_pkg::DEF_WEIGHT_BITS
) (
    input  logic signed [ssp_pkg::DIST_W-1:0] i_dist_from,
    input  logic signed [ssp_pkg::DIST_W-1:0] i_dist_to,
    input  logic                              i_to_reached,
    input  logic signed [WEIGHT_BITS-1:0]     i_weight,
    output ssp_pkg::t_relax                   o_relax
);

    localparam int SW = ((ssp_pkg::DIST_W > WEIGHT_BITS) ? ssp_pkg::DIST_W : WEIGHT_BITS) + 1;

    logic signed [SW-1:0]              sum;
    logic signed [ssp_pkg::DIST_W-1:0] cand;

    assign sum = SW'(i_dist_from) + SW'(i_weight);

    // Clamp the sum to the distance range before comparing
    always_comb begin
        if (sum > SW'(ssp_pkg::DIST_MAX)) begin
            cand = ssp_pkg::DIST_MAX;
        end else if (sum < SW'(ssp_pkg::DIST_MIN)) begin
            cand = ssp_pkg::DIST_MIN;
        end else begin
            cand = ssp_pkg::DIST_W'(sum);
        end
    end

    assign o_relax.cand    = cand;
    assign o_relax.improve = !i_to_reached || (i_dist_to > cand);

endmodule
